[rtl/core/world_to_screen_projector_top_defines.svh]
// Assertion macros shared by the projector RTL.
`ifndef WORLD_TO_SCREEN_PROJECTOR_TOP_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define WTSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define WTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define WTSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define WTSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/core/wtsp_pkg.sv]
package wtsp_pkg;

  localparam int ENTRY_W = 16;
  localparam int COORD_W = 24;
  localparam int PROD_W  = ENTRY_W + COORD_W;
  localparam int V_W     = PROD_W + 2;
  localparam int V_LO_W  = 21;
  localparam int V_HI_W  = V_W - V_LO_W;
  localparam int HSUM_W  = ENTRY_W + V_HI_W + 2;
  localparam int LSUM_W  = ENTRY_W + V_LO_W + 1 + 2;
  localparam int ACC_W   = 60;
  localparam int CLIP_W  = ACC_W - 10;
  localparam int CLIP_LO_W = 25;
  localparam int NUM_W   = 64;
  localparam int DEN_W   = CLIP_W;
  localparam int OUT_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 64;

  localparam logic [DEN_W-1:0] W_THRESHOLD = DEN_W'(105);
  localparam logic signed [OUT_W-1:0] OUT_MAX  = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN  = -24'sh800000;
  localparam logic signed [OUT_W-1:0] DEGEN_XY = -24'sd16;
  localparam logic signed [COORD_W-1:0] ONE_Q10 = 24'sd1024;
  localparam logic [CFG_W-1:0] ID_ROW0 = 64'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_ROW0 = 3'd0,
    CFG_VIEW_ROW1 = 3'd1,
    CFG_VIEW_ROW2 = 3'd2,
    CFG_VIEW_ROW3 = 3'd3,
    CFG_PROJ_ROW0 = 3'd4,
    CFG_PROJ_ROW1 = 3'd5,
    CFG_PROJ_ROW2 = 3'd6,
    CFG_PROJ_ROW3 = 3'd7
  } cfg_reg_t;

  // Pick column c of a packed matrix row.
  function automatic logic signed [ENTRY_W-1:0] mat_entry(input logic [CFG_W-1:0] row,
                                                          input int c);
    return $signed(row[ENTRY_W*c +: ENTRY_W]);
  endfunction

endpackage

[rtl/core/wtsp_div_pipe.sv]
`include "world_to_screen_projector_top_defines.svh"
module wtsp_div_pipe import wtsp_pkg::*; #(
  parameter int N_W    = 64,
  parameter int D_W    = 50,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [N_W-1:0]    in_num,
  input  logic [D_W-1:0]    in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [N_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic [N_W-1:0]    vld_r;
  logic [D_W-1:0]    rem_r   [N_W];
  logic [D_W-1:0]    rem_nxt [N_W];
  logic [N_W-1:0]    nq_r    [N_W];
  logic [N_W-1:0]    nq_nxt  [N_W];
  logic [D_W-1:0]    den_r   [N_W];
  logic [D_W-1:0]    den_nxt [N_W];
  logic [SIDE_W-1:0] side_r  [N_W];
  logic [SIDE_W-1:0] side_nxt[N_W];

  // One restoring step per stage: numerator bits shift out, quotient bits in.
  always_comb begin
    logic [D_W-1:0] rem_in;
    logic [N_W-1:0] nq_in;
    logic [D_W:0]   trial;
    for (int k = 0; k < N_W; k++) begin
      if (k == 0) begin
        rem_in      = '0;
        nq_in       = in_num;
        den_nxt[k]  = in_den;
        side_nxt[k] = in_side;
      end else begin
        rem_in      = rem_r[k-1];
        nq_in       = nq_r[k-1];
        den_nxt[k]  = den_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      trial = {rem_in, nq_in[N_W-1]};
      if (trial >= {1'b0, den_nxt[k]}) begin
        rem_nxt[k] = D_W'(trial - {1'b0, den_nxt[k]});
        nq_nxt[k]  = {nq_in[N_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = D_W'(trial);
        nq_nxt[k]  = {nq_in[N_W-2:0], 1'b0};
      end
    end
  end

  // Advance valid bits with the stall enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N_W-2:0], in_valid};
    end
  end

  // Advance payload; hold on stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < N_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        nq_r[k]   <= nq_nxt[k];
        den_r[k]  <= den_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[N_W-1];
  assign out_quo   = nq_r[N_W-1];
  assign out_side  = side_r[N_W-1];

  `WTSP_ASSERT_IMPLY(a_rem_below_den, clk, rst_n, vld_r[N_W-1] && (den_r[N_W-1] != '0), rem_r[N_W-1] < den_r[N_W-1], "divider remainder not below divisor")
  `WTSP_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(vld_r), "divider valid bits moved during stall")
  `WTSP_ASSERT_NEXT(a_first_stage, clk, rst_n, adv, vld_r[0] == $past(in_valid), "divider first stage lost a beat")

endmodule

[rtl/core/world_to_screen_projector_top.sv]
// An accepted input beat passes stages 1 to 9, the two dividers, then post 1 and post 2 to its result beat.
// Throughput: one point per clock; a stalled output freezes the whole pipeline.
// Latency is set by the two 64-stage restoring dividers (one quotient bit per stage).
// Reset (synchronous, rst_n low): clears all valid bits, loads identity matrices.
`include "world_to_screen_projector_top_defines.svh"
module world_to_screen_projector_top import wtsp_pkg::*; #(
  parameter int SCREEN_WIDTH  = 1024,
  parameter int SCREEN_HEIGHT = 768
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_world_x,
  input  logic signed [COORD_W-1:0] in_world_y,
  input  logic signed [COORD_W-1:0] in_world_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [OUT_W-1:0]   out_screen_x,
  output logic signed [OUT_W-1:0]   out_screen_y,
  output logic                      out_degenerate
);

  localparam int DIM_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int NP_W    = CLIP_LO_W + DIM_W + 2;
  localparam int RES_W   = NUM_W + 1;
  localparam int SUM_W   = NUM_W + 2;
  localparam int HI_P_W  = ENTRY_W + V_HI_W;
  localparam int LO_P_W  = ENTRY_W + V_LO_W + 1;
  localparam logic signed [DIM_W:0]   W_VAL = (DIM_W+1)'(SCREEN_WIDTH);
  localparam logic signed [DIM_W:0]   H_VAL = (DIM_W+1)'(SCREEN_HEIGHT);
  localparam logic signed [SUM_W-1:0] WX8   = SUM_W'(SCREEN_WIDTH * 8);
  localparam logic signed [SUM_W-1:0] HX8   = SUM_W'(SCREEN_HEIGHT * 8);
  localparam int CLIP_ROW [3] = '{0, 1, 3};

  logic adv;
  logic [CFG_W-1:0] view_r [4];
  logic [CFG_W-1:0] proj_r [4];

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        view_r[i] <= ID_ROW0 << (ENTRY_W * i);
        proj_r[i] <= ID_ROW0 << (ENTRY_W * i);
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VIEW_ROW0: view_r[0] <= cfg_wdata;
        CFG_VIEW_ROW1: view_r[1] <= cfg_wdata;
        CFG_VIEW_ROW2: view_r[2] <= cfg_wdata;
        CFG_VIEW_ROW3: view_r[3] <= cfg_wdata;
        CFG_PROJ_ROW0: proj_r[0] <= cfg_wdata;
        CFG_PROJ_ROW1: proj_r[1] <= cfg_wdata;
        CFG_PROJ_ROW2: proj_r[2] <= cfg_wdata;
        CFG_PROJ_ROW3: proj_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output register is empty or being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s6_vld_r, s7_vld_r, s8_vld_r, s9_vld_r, p1_vld_r, out_vld_r;
  logic div_vld, div_y_vld;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0; s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0; s6_vld_r <= 1'b0; s7_vld_r <= 1'b0; s8_vld_r <= 1'b0;
      s9_vld_r <= 1'b0; p1_vld_r <= 1'b0; out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid; s2_vld_r <= s1_vld_r; s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r; s5_vld_r <= s4_vld_r; s6_vld_r <= s5_vld_r;
      s7_vld_r <= s6_vld_r; s8_vld_r <= s7_vld_r; s9_vld_r <= s8_vld_r;
      p1_vld_r <= div_vld;  out_vld_r <= p1_vld_r;
    end
  end

  // Stage 1: view matrix products.
  logic signed [COORD_W-1:0] p_in [4];
  logic signed [PROD_W-1:0]  s1_prod_r [4][4];
  assign p_in[0] = in_world_x;
  assign p_in[1] = in_world_y;
  assign p_in[2] = in_world_z;
  assign p_in[3] = ONE_Q10;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          s1_prod_r[r][c] <= PROD_W'(mat_entry(view_r[r], c)) * PROD_W'(p_in[c]);
        end
      end
    end
  end

  // Stage 2: view row sums, Q20.
  logic signed [V_W-1:0] s2_v_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        s2_v_r[r] <= V_W'(s1_prod_r[r][0]) + V_W'(s1_prod_r[r][1])
                   + V_W'(s1_prod_r[r][2]) + V_W'(s1_prod_r[r][3]);
      end
    end
  end

  // Stage 3: projection partial products, v split into high and low halves.
  logic signed [HI_P_W-1:0] s3_hi_r [3][4];
  logic signed [LO_P_W-1:0] s3_lo_r [3][4];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 4; c++) begin
          s3_hi_r[k][c] <= HI_P_W'(mat_entry(proj_r[CLIP_ROW[k]], c))
                         * HI_P_W'($signed(s2_v_r[c][V_W-1:V_LO_W]));
          s3_lo_r[k][c] <= LO_P_W'(mat_entry(proj_r[CLIP_ROW[k]], c))
                         * LO_P_W'($signed({1'b0, s2_v_r[c][V_LO_W-1:0]}));
        end
      end
    end
  end

  // Stage 4: partial sums per clip row.
  logic signed [HSUM_W-1:0] s4_hsum_r [3];
  logic signed [LSUM_W-1:0] s4_lsum_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s4_hsum_r[k] <= HSUM_W'(s3_hi_r[k][0]) + HSUM_W'(s3_hi_r[k][1])
                      + HSUM_W'(s3_hi_r[k][2]) + HSUM_W'(s3_hi_r[k][3]);
        s4_lsum_r[k] <= LSUM_W'(s3_lo_r[k][0]) + LSUM_W'(s3_lo_r[k][1])
                      + LSUM_W'(s3_lo_r[k][2]) + LSUM_W'(s3_lo_r[k][3]);
      end
    end
  end

  // Stage 5: merge halves, round Q30 to Q20 (ties toward +inf).
  logic signed [ACC_W-1:0]  s5_acc_nxt [3];
  logic signed [CLIP_W-1:0] s5_clip_r  [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s5_acc_nxt[k] = (ACC_W'(s4_hsum_r[k]) <<< V_LO_W) + ACC_W'(s4_lsum_r[k])
                    + ACC_W'(512);
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s5_clip_r[k] <= $signed(s5_acc_nxt[k][ACC_W-1:10]);
      end
    end
  end

  // Stage 6: |w|, degenerate test, numerator partial products.
  logic [DEN_W-1:0]        s6_aw_nxt;
  logic [DEN_W-1:0]        s6_aw_r;
  logic                    s6_deg_r, s6_wneg_r;
  logic signed [NP_W-1:0]  s6_nxh_r, s6_nxl_r, s6_nyh_r, s6_nyl_r;
  assign s6_aw_nxt = s5_clip_r[2][CLIP_W-1] ? DEN_W'(-s5_clip_r[2]) : DEN_W'(s5_clip_r[2]);
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_aw_r   <= s6_aw_nxt;
      s6_deg_r  <= s6_aw_nxt < W_THRESHOLD;
      s6_wneg_r <= s5_clip_r[2][CLIP_W-1];
      s6_nxh_r  <= NP_W'($signed(s5_clip_r[0][CLIP_W-1:CLIP_LO_W])) * NP_W'(W_VAL);
      s6_nxl_r  <= NP_W'($signed({1'b0, s5_clip_r[0][CLIP_LO_W-1:0]})) * NP_W'(W_VAL);
      s6_nyh_r  <= NP_W'($signed(s5_clip_r[1][CLIP_W-1:CLIP_LO_W])) * NP_W'(H_VAL);
      s6_nyl_r  <= NP_W'($signed({1'b0, s5_clip_r[1][CLIP_LO_W-1:0]})) * NP_W'(H_VAL);
    end
  end

  // Stage 7: numerators clip*dim*8, wrapped to 64 bits.
  logic signed [NUM_W-1:0] s7_nx_r, s7_ny_r;
  logic [DEN_W-1:0]        s7_aw_r;
  logic                    s7_deg_r, s7_wneg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_nx_r   <= ((NUM_W'(s6_nxh_r) <<< CLIP_LO_W) + NUM_W'(s6_nxl_r)) <<< 3;
      s7_ny_r   <= ((NUM_W'(s6_nyh_r) <<< CLIP_LO_W) + NUM_W'(s6_nyl_r)) <<< 3;
      s7_aw_r   <= s6_aw_r;
      s7_deg_r  <= s6_deg_r;
      s7_wneg_r <= s6_wneg_r;
    end
  end

  // Stage 8: magnitudes and quotient signs.
  logic [NUM_W-1:0] s8_unx_r, s8_uny_r;
  logic [DEN_W-1:0] s8_aw_r;
  logic             s8_deg_r, s8_negx_r, s8_negy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_unx_r  <= s7_nx_r[NUM_W-1] ? NUM_W'(-s7_nx_r) : NUM_W'(s7_nx_r);
      s8_uny_r  <= s7_ny_r[NUM_W-1] ? NUM_W'(-s7_ny_r) : NUM_W'(s7_ny_r);
      s8_negx_r <= s7_nx_r[NUM_W-1] ^ s7_wneg_r;
      s8_negy_r <= s7_ny_r[NUM_W-1] ^ s7_wneg_r;
      s8_aw_r   <= s7_aw_r;
      s8_deg_r  <= s7_deg_r;
    end
  end

  // Stage 9: add half divisor for round to nearest.
  logic [NUM_W-1:0] s9_numx_r, s9_numy_r;
  logic [DEN_W-1:0] s9_aw_r;
  logic             s9_deg_r, s9_negx_r, s9_negy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_numx_r <= s8_unx_r + NUM_W'(s8_aw_r >> 1);
      s9_numy_r <= s8_uny_r + NUM_W'(s8_aw_r >> 1);
      s9_aw_r   <= s8_aw_r;
      s9_deg_r  <= s8_deg_r;
      s9_negx_r <= s8_negx_r;
      s9_negy_r <= s8_negy_r;
    end
  end

  // Dividers: x lane carries the degenerate flag along.
  logic [NUM_W-1:0] qx, qy;
  logic [1:0]       side_x;
  logic             side_y;

  wtsp_div_pipe #(.N_W(NUM_W), .D_W(DEN_W), .SIDE_W(2)) u_div_x (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(s9_vld_r), .in_num(s9_numx_r), .in_den(s9_aw_r),
    .in_side({s9_deg_r, s9_negx_r}),
    .out_valid(div_vld), .out_quo(qx), .out_side(side_x)
  );

  wtsp_div_pipe #(.N_W(NUM_W), .D_W(DEN_W), .SIDE_W(1)) u_div_y (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_valid(s9_vld_r), .in_num(s9_numy_r), .in_den(s9_aw_r),
    .in_side(s9_negy_r),
    .out_valid(div_y_vld), .out_quo(qy), .out_side(side_y)
  );

  // Post 1: apply quotient sign.
  logic signed [RES_W-1:0] p1_rx_r, p1_ry_r;
  logic                    p1_deg_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rx_r  <= side_x[0] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      p1_ry_r  <= side_y    ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      p1_deg_r <= side_x[1];
    end
  end

  // Post 2: viewport offset, saturate, degenerate override into the output register.
  logic signed [SUM_W-1:0] sx_sum, sy_sum;
  logic signed [OUT_W-1:0] sx_nxt, sy_nxt;
  logic signed [OUT_W-1:0] out_sx_r, out_sy_r;
  logic                    out_deg_r;
  assign sx_sum = SUM_W'(p1_rx_r) + WX8;
  assign sy_sum = HX8 - SUM_W'(p1_ry_r);

  always_comb begin
    if (p1_deg_r) begin
      sx_nxt = DEGEN_XY;
      sy_nxt = DEGEN_XY;
    end else begin
      if (sx_sum > SUM_W'(OUT_MAX))      sx_nxt = OUT_MAX;
      else if (sx_sum < SUM_W'(OUT_MIN)) sx_nxt = OUT_MIN;
      else                               sx_nxt = OUT_W'(sx_sum);
      if (sy_sum > SUM_W'(OUT_MAX))      sy_nxt = OUT_MAX;
      else if (sy_sum < SUM_W'(OUT_MIN)) sy_nxt = OUT_MIN;
      else                               sy_nxt = OUT_W'(sy_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sx_r  <= sx_nxt;
      out_sy_r  <= sy_nxt;
      out_deg_r <= p1_deg_r;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_screen_x   = out_sx_r;
  assign out_screen_y   = out_sy_r;
  assign out_degenerate = out_deg_r;

  `WTSP_ASSERT_IMPLY(a_degen_coords, clk, rst_n, out_valid && out_degenerate, (out_screen_x == DEGEN_XY) && (out_screen_y == DEGEN_XY), "degenerate beat without -1,-1 pixel")
  `WTSP_ASSERT_IMPLY(a_lanes_aligned, clk, rst_n, 1'b1, div_vld == div_y_vld, "divider lanes out of step")
  `WTSP_ASSERT_NEXT(a_stall_holds, clk, rst_n, !adv, $stable(s9_vld_r) && $stable(p1_vld_r), "pipeline moved during stall")
  `WTSP_ASSERT_IMPLY(a_entry_from_accept, clk, rst_n, $rose(s1_vld_r), $past(in_valid && in_ready), "stage 1 filled without an accepted beat")

endmodule
